// ===== hw/rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_BLOCKS  = 256;
  localparam int unsigned DEF_ALIGN_BYTES = 8;
  localparam int unsigned DEF_MIN_BLOCK   = 32;

  // Fixed field widths.
  localparam int unsigned CNT_W    = 20;  // byte counters and pool size
  localparam int unsigned BLK_W    = 16;  // requested block size
  localparam int unsigned EFF_W    = 17;  // effective block size after rounding
  localparam int unsigned IDX_W    = 8;   // block index fields
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // Reciprocal used to divide by the alignment without a divider.
  localparam int unsigned RECIP_SHIFT = 24;

  // Register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_POOL_BYTES  = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_BLOCK = 2'd1,
    STATUS_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_ROUND,
    ST_INIT_SCALE,
    ST_INIT_DIV,
    ST_INIT_FILL,
    ST_ALLOC_LINK,
    ST_ALLOC_FIXNEXT,
    ST_ALLOC_FINISH,
    ST_FREE_CHECK,
    ST_FREE_PUSH,
    ST_FREE_FINISH,
    ST_RST_MOVE,
    ST_RST_LINK
  } state_e;

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
module fbpa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and a registered read port; no reset on contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
// Channel   Direction  Signals                                   Handshake
// --------  ---------  ----------------------------------------  -------------------------------
// command   in         mode_i, block_index_i                     start && !busy
// result    out        status_o, granted_index_o, used_bytes_o,  done_o, one cycle, no stall
//                      free_bytes_o, pool_full_o
// config    in/out     psel, penable, pwrite, paddr, pwdata,     psel && penable && pwrite
//                      prdata, pready
//
// One sequencer works each command alone; busy is high from the accepting edge to the last
// step, done_o pulses in the next cycle, and a new command may be taken in that cycle.
// Allocate links, fixes next and finishes; a good free checks, pushes and finishes; a free of a
// block already free stops at the check; an empty-pool allocate or out-of-range free stays idle;
// reset moves and links each allocated block; init rounds, scales, divides and links each block.
// Reset leaves both lists empty and the counters at zero; the receiver cannot stall results.
module fixed_block_pool_allocator #(
  parameter int unsigned MAX_BLOCKS  = fbpa_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned ALIGN_BYTES = fbpa_pkg::DEF_ALIGN_BYTES,
  parameter int unsigned MIN_BLOCK   = fbpa_pkg::DEF_MIN_BLOCK
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           start,
  output logic                           busy,
  input  logic [fbpa_pkg::MODE_W-1:0]    mode_i,
  input  logic [fbpa_pkg::IDX_W-1:0]     block_index_i,

  output logic                           done_o,
  output logic [fbpa_pkg::STATUS_W-1:0]  status_o,
  output logic [fbpa_pkg::IDX_W-1:0]     granted_index_o,
  output logic [fbpa_pkg::CNT_W-1:0]     used_bytes_o,
  output logic [fbpa_pkg::CNT_W-1:0]     free_bytes_o,
  output logic                           pool_full_o,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // Memory address width and link width; a link of value MAX_BLOCKS is the null marker.
  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned LW = $clog2(MAX_BLOCKS) + 1;
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);

  localparam int unsigned CW    = fbpa_pkg::CNT_W;
  localparam int unsigned EW    = fbpa_pkg::EFF_W;
  localparam int unsigned RW    = fbpa_pkg::RECIP_SHIFT + 1;
  localparam int unsigned RECIP = ((1 << fbpa_pkg::RECIP_SHIFT) + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int unsigned DW    = $clog2(CW);

  fbpa_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [CW-1:0]               pool_bytes_q;
  logic [fbpa_pkg::BLK_W-1:0]  block_bytes_q;

  // Allocator state.
  logic [EW-1:0] eff_q, eff_d;
  logic [LW-1:0] active_q, active_d;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [LW-1:0] alloc_head_q, alloc_head_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] freec_q, freec_d;

  // Sequencer working registers.
  logic [EW-1:0] work_q, work_d;
  logic [EW:0]   rem_q, rem_d;
  logic [CW-1:0] quo_q, quo_d;
  logic [DW-1:0] dcnt_q, dcnt_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] nxt_q, nxt_d;

  // Result registers.
  logic                          done_q, done_d;
  logic [fbpa_pkg::STATUS_W-1:0] status_q, status_d;
  logic [fbpa_pkg::IDX_W-1:0]    granted_q, granted_d;

  // Link memory ports.
  logic          nx_we, pv_we, fl_we;
  logic [AW-1:0] nx_waddr, pv_waddr, fl_waddr, raddr;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  logic          fl_wdata, fl_rdata;

  // Datapath helpers.
  logic [fbpa_pkg::BLK_W-1:0] blk_clamped;
  logic [EW+RW-1:0]           recip_prod;
  logic [EW:0]                rem_shift, rem_trial;
  logic                       rem_fits;
  logic [CW-1:0]              quo_next;
  logic [CW:0]                used_sum, free_sum;
  logic [CW-1:0]              eff_ext;
  logic [CW-1:0]              used_inc, used_dec, free_inc, free_dec;
  logic                       cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port: two registers at byte addresses 0 and 4.
  // ---------------------------------------------------------------------------
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_bytes_q  <= '0;
      block_bytes_q <= fbpa_pkg::BLK_W'(64);
    end else if (cfg_wr) begin
      if (paddr[2] == fbpa_pkg::REG_POOL_BYTES) begin
        pool_bytes_q <= pwdata[CW-1:0];
      end else begin
        block_bytes_q <= pwdata[fbpa_pkg::BLK_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fbpa_pkg::REG_BLOCK_BYTES) begin
      prdata = {{(32 - fbpa_pkg::BLK_W){1'b0}}, block_bytes_q};
    end else begin
      prdata = {{(32 - CW){1'b0}}, pool_bytes_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Shared arithmetic.
  // ---------------------------------------------------------------------------
  // Block size raised to the minimum; the alignment rounding divides by the
  // alignment through a reciprocal multiply that is exact for 17-bit values.
  assign blk_clamped = (block_bytes_q < fbpa_pkg::BLK_W'(MIN_BLOCK)) ?
                       fbpa_pkg::BLK_W'(MIN_BLOCK) : block_bytes_q;
  assign recip_prod  = (EW+RW)'(work_q) * (EW+RW)'(RECIP);

  // One restoring divide step: the pool size divided by the block size.
  assign rem_shift = {rem_q[EW-1:0], quo_q[CW-1]};
  assign rem_trial = rem_shift - {1'b0, eff_q};
  assign rem_fits  = rem_shift >= {1'b0, eff_q};
  assign quo_next  = {quo_q[CW-2:0], rem_fits};

  // Saturating counter updates by one block.
  assign eff_ext  = CW'(eff_q);
  assign used_sum = {1'b0, used_q} + {1'b0, eff_ext};
  assign free_sum = {1'b0, freec_q} + {1'b0, eff_ext};
  assign used_inc = used_sum[CW] ? {CW{1'b1}} : used_sum[CW-1:0];
  assign free_inc = free_sum[CW] ? {CW{1'b1}} : free_sum[CW-1:0];
  assign used_dec = (used_q > eff_ext) ? used_q - eff_ext : '0;
  assign free_dec = (freec_q > eff_ext) ? freec_q - eff_ext : '0;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    eff_d        = eff_q;
    active_d     = active_q;
    free_head_d  = free_head_q;
    alloc_head_d = alloc_head_q;
    used_d       = used_q;
    freec_d      = freec_q;
    work_d       = work_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dcnt_d       = dcnt_q;
    cur_d        = cur_q;
    nxt_d        = nxt_q;
    done_d       = 1'b0;
    status_d     = status_q;
    granted_d    = granted_q;

    nx_we    = 1'b0;
    nx_waddr = cur_q[AW-1:0];
    nx_wdata = NIL;
    pv_we    = 1'b0;
    pv_waddr = cur_q[AW-1:0];
    pv_wdata = NIL;
    fl_we    = 1'b0;
    fl_waddr = cur_q[AW-1:0];
    fl_wdata = 1'b0;
    raddr    = cur_q[AW-1:0];

    case (state_q)
      fbpa_pkg::ST_IDLE: begin
        // The read address is set up ahead so the link is ready in the first step.
        case (mode_i)
          fbpa_pkg::MODE_FREE:  raddr = AW'(block_index_i);
          fbpa_pkg::MODE_RESET: raddr = alloc_head_q[AW-1:0];
          default:              raddr = free_head_q[AW-1:0];
        endcase
        if (start) begin
          status_d  = fbpa_pkg::STATUS_OK;
          granted_d = '0;
          case (mode_i)
            fbpa_pkg::MODE_INIT: begin
              work_d  = EW'(blk_clamped) + EW'(ALIGN_BYTES - 1);
              state_d = fbpa_pkg::ST_INIT_ROUND;
            end
            fbpa_pkg::MODE_ALLOC: begin
              cur_d = free_head_q;
              if (free_head_q < NIL) begin
                state_d = fbpa_pkg::ST_ALLOC_LINK;
              end else begin
                status_d = fbpa_pkg::STATUS_NO_BLOCK;
                done_d   = 1'b1;
              end
            end
            fbpa_pkg::MODE_FREE: begin
              cur_d = LW'(block_index_i);
              if ((LW + fbpa_pkg::IDX_W)'(block_index_i) < (LW + fbpa_pkg::IDX_W)'(active_q)) begin
                state_d = fbpa_pkg::ST_FREE_CHECK;
              end else begin
                status_d = fbpa_pkg::STATUS_BAD_FREE;
                done_d   = 1'b1;
              end
            end
            default: begin
              cur_d = alloc_head_q;
              if (alloc_head_q < NIL) begin
                state_d = fbpa_pkg::ST_RST_MOVE;
              end else begin
                used_d  = '0;
                freec_d = pool_bytes_q;
                done_d  = 1'b1;
              end
            end
          endcase
        end
      end

      fbpa_pkg::ST_INIT_ROUND: begin
        work_d  = recip_prod[fbpa_pkg::RECIP_SHIFT +: EW];
        state_d = fbpa_pkg::ST_INIT_SCALE;
      end

      fbpa_pkg::ST_INIT_SCALE: begin
        eff_d   = EW'(work_q * EW'(ALIGN_BYTES));
        rem_d   = '0;
        quo_d   = pool_bytes_q;
        dcnt_d  = '0;
        state_d = fbpa_pkg::ST_INIT_DIV;
      end

      fbpa_pkg::ST_INIT_DIV: begin
        rem_d  = rem_fits ? rem_trial : rem_shift;
        quo_d  = quo_next;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DW'(CW - 1)) begin
          // Block count, capped at the memory depth; both lists start empty.
          active_d     = (quo_next > CW'(MAX_BLOCKS)) ? NIL : LW'(quo_next);
          free_head_d  = NIL;
          alloc_head_d = NIL;
          used_d       = '0;
          freec_d      = pool_bytes_q;
          cur_d        = '0;
          state_d      = fbpa_pkg::ST_INIT_FILL;
        end
      end

      fbpa_pkg::ST_INIT_FILL: begin
        // Block i links down to i-1 and back up to i+1; the highest block heads the list.
        if (cur_q == active_q) begin
          done_d  = 1'b1;
          state_d = fbpa_pkg::ST_IDLE;
        end else begin
          nx_we       = 1'b1;
          nx_wdata    = (cur_q == '0) ? NIL : cur_q - 1'b1;
          pv_we       = 1'b1;
          pv_wdata    = (cur_q + 1'b1 == active_q) ? NIL : cur_q + 1'b1;
          fl_we       = 1'b1;
          fl_wdata    = 1'b1;
          free_head_d = cur_q;
          cur_d       = cur_q + 1'b1;
        end
      end

      fbpa_pkg::ST_ALLOC_LINK: begin
        // Pop the free head and link it in front of the allocated list.
        free_head_d = nx_rdata;
        nx_we       = 1'b1;
        nx_wdata    = alloc_head_q;
        pv_we       = 1'b1;
        pv_wdata    = NIL;
        fl_we       = 1'b1;
        fl_wdata    = 1'b0;
        state_d     = fbpa_pkg::ST_ALLOC_FIXNEXT;
      end

      fbpa_pkg::ST_ALLOC_FIXNEXT: begin
        pv_we    = free_head_q < NIL;
        pv_waddr = free_head_q[AW-1:0];
        pv_wdata = NIL;
        state_d  = fbpa_pkg::ST_ALLOC_FINISH;
      end

      fbpa_pkg::ST_ALLOC_FINISH: begin
        pv_we        = alloc_head_q < NIL;
        pv_waddr     = alloc_head_q[AW-1:0];
        pv_wdata     = cur_q;
        alloc_head_d = cur_q;
        used_d       = used_inc;
        freec_d      = free_dec;
        granted_d    = fbpa_pkg::IDX_W'(cur_q);
        done_d       = 1'b1;
        state_d      = fbpa_pkg::ST_IDLE;
      end

      fbpa_pkg::ST_FREE_CHECK: begin
        if (fl_rdata) begin
          status_d = fbpa_pkg::STATUS_BAD_FREE;
          done_d   = 1'b1;
          state_d  = fbpa_pkg::ST_IDLE;
        end else begin
          // Unlink from the allocated list.
          nx_we    = pv_rdata < NIL;
          nx_waddr = pv_rdata[AW-1:0];
          nx_wdata = nx_rdata;
          if (pv_rdata >= NIL) begin
            alloc_head_d = nx_rdata;
          end
          pv_we    = nx_rdata < NIL;
          pv_waddr = nx_rdata[AW-1:0];
          pv_wdata = pv_rdata;
          fl_we    = 1'b1;
          fl_wdata = 1'b1;
          state_d  = fbpa_pkg::ST_FREE_PUSH;
        end
      end

      fbpa_pkg::ST_FREE_PUSH: begin
        nx_we    = 1'b1;
        nx_wdata = free_head_q;
        pv_we    = 1'b1;
        pv_wdata = NIL;
        state_d  = fbpa_pkg::ST_FREE_FINISH;
      end

      fbpa_pkg::ST_FREE_FINISH: begin
        pv_we       = free_head_q < NIL;
        pv_waddr    = free_head_q[AW-1:0];
        pv_wdata    = cur_q;
        free_head_d = cur_q;
        used_d      = used_dec;
        freec_d     = free_inc;
        done_d      = 1'b1;
        state_d     = fbpa_pkg::ST_IDLE;
      end

      fbpa_pkg::ST_RST_MOVE: begin
        // Push the current allocated block onto the free list.
        nxt_d    = nx_rdata;
        nx_we    = 1'b1;
        nx_wdata = free_head_q;
        pv_we    = 1'b1;
        pv_wdata = NIL;
        fl_we    = 1'b1;
        fl_wdata = 1'b1;
        state_d  = fbpa_pkg::ST_RST_LINK;
      end

      fbpa_pkg::ST_RST_LINK: begin
        pv_we       = free_head_q < NIL;
        pv_waddr    = free_head_q[AW-1:0];
        pv_wdata    = cur_q;
        free_head_d = cur_q;
        cur_d       = nxt_q;
        raddr       = nxt_q[AW-1:0];
        if (nxt_q < NIL) begin
          state_d = fbpa_pkg::ST_RST_MOVE;
        end else begin
          alloc_head_d = NIL;
          used_d       = '0;
          freec_d      = pool_bytes_q;
          done_d       = 1'b1;
          state_d      = fbpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fbpa_pkg::ST_IDLE;
      eff_q        <= '0;
      active_q     <= '0;
      free_head_q  <= NIL;
      alloc_head_q <= NIL;
      used_q       <= '0;
      freec_q      <= '0;
      dcnt_q       <= '0;
      cur_q        <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      eff_q        <= eff_d;
      active_q     <= active_d;
      free_head_q  <= free_head_d;
      alloc_head_q <= alloc_head_d;
      used_q       <= used_d;
      freec_q      <= freec_d;
      dcnt_q       <= dcnt_d;
      cur_q        <= cur_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    nxt_q     <= nxt_d;
    status_q  <= status_d;
    granted_q <= granted_d;
  end

  // ---------------------------------------------------------------------------
  // Link memories.
  // ---------------------------------------------------------------------------
  fbpa_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (raddr),
    .rdata_o (nx_rdata)
  );

  fbpa_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pv_we),
    .waddr_i (pv_waddr),
    .wdata_i (pv_wdata),
    .raddr_i (raddr),
    .rdata_o (pv_rdata)
  );

  fbpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (raddr),
    .rdata_o (fl_rdata)
  );

  // ---------------------------------------------------------------------------
  // Outputs. The counters hold their final values from the last step on, so
  // they are stable while the result strobe is high.
  // ---------------------------------------------------------------------------
  assign busy            = (state_q != fbpa_pkg::ST_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign used_bytes_o    = used_q;
  assign free_bytes_o    = freec_q;
  assign pool_full_o     = (free_head_q >= NIL);

endmodule
